FILE: hw/rtl/i2cm_pkg.sv
// ============================================================================
// i2cm_pkg
// shared types and constants of the i2c master byte engine
// ============================================================================
`default_nettype none

package i2cm_pkg;

    // item modes on the input stream
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    localparam int          BITS_PER_BYTE   = 8;
    localparam logic [15:0] HALF_PERIOD_RST = 16'd250;
    localparam int          QUEUE_DEPTH     = 2;

    // what the front end made of one item
    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_START,
        KIND_STOP,
        KIND_WRITE,
        KIND_READ,
        KIND_NONE
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  write_byte;
        logic        send_ack;
        logic        sda_in;
    } queue_entry_t;

    // pin sequencer phases
    typedef enum logic [12:0] {
        PH_IDLE    = 13'b0_0000_0000_0001,
        PH_ST1     = 13'b0_0000_0000_0010,
        PH_ST2     = 13'b0_0000_0000_0100,
        PH_SP1     = 13'b0_0000_0000_1000,
        PH_SP2     = 13'b0_0000_0001_0000,
        PH_WB_LOW  = 13'b0_0000_0010_0000,
        PH_WB_HIGH = 13'b0_0000_0100_0000,
        PH_WA_LOW  = 13'b0_0000_1000_0000,
        PH_WA_HIGH = 13'b0_0001_0000_0000,
        PH_RB_HIGH = 13'b0_0010_0000_0000,
        PH_RB_LOW  = 13'b0_0100_0000_0000,
        PH_RA_LOW  = 13'b0_1000_0000_0000,
        PH_RA_HIGH = 13'b1_0000_0000_0000
    } phase_t;

endpackage

`default_nettype wire

FILE: hw/rtl/i2c_master_byte_engine.sv
// ============================================================================
// i2c_master_byte_engine
// i2c master pin sequencer driven by command and tick items
// ============================================================================
// usage
//   s_* carries one item per transfer: s_tuser holds the mode (tick, start,
//   stop, write byte, read byte), s_tdata the byte, ack bit and sampled sda
//   m_* returns exactly one result per item: scl, sda, sda drive enable,
//   busy, done, last ack and last read byte
//   cfg_* writes the half period in ticks; write it only while idle
//   a front end classifies each item into a short queue; the back end pops
//   one entry per cycle unless an untaken result waits, steps the pin sequencer
//   and loads the output register; a result passes the queue, then the register
//   throughput: one item per cycle while m_tready is high, set by the single
//   step of the sequencer per popped entry; while m_tready is low the output
//   register holds one result and the queue takes QUEUE_DEPTH more items,
//   then s_tready drops
//   reset: bus lines high and sda released, sequencer idle, half period 250
//   commands given while busy and unknown modes still yield a result
// ============================================================================
`default_nettype none

module i2c_master_byte_engine
#(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [15:0] cfg_data,     // half_period_ticks
    // input stream
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [2:0]  s_tuser,      // mode
    input  wire logic [15:0] s_tdata,      // write_byte, send_ack, sda_in, zero fill
    // result stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata       // scl_level, sda_level, sda_drive, busy_res,
                                           // done_res, ack_received, read_byte, zero fill
);

    i2cm_pkg::queue_entry_t push_entry;
    i2cm_pkg::queue_entry_t head_entry;
    logic q_push;
    logic q_full;
    logic q_not_empty;
    logic q_pop;

    // the register is a plain flop, a write always lands
    assign cfg_ready = 1'b1;

    // classify incoming transfers
    i2cm_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    // decouples input acceptance from result stalls
    i2cm_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .pop        (q_pop),
        .head       (head_entry)
    );

    // sequencer and output register
    i2cm_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .q_not_empty (q_not_empty),
        .q_head      (head_entry),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/i2cm_front.sv
// ============================================================================
// i2cm_front
// accepts input transfers and classifies them into queue entries
// ============================================================================
`default_nettype none

module i2cm_front
(
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [2:0]             s_tuser,
    input  wire logic [15:0]            s_tdata,
    input  wire logic                   q_full,
    output      logic                   q_push,
    output      i2cm_pkg::queue_entry_t q_entry
);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_entry.write_byte = s_tdata[7:0];
        q_entry.send_ack   = s_tdata[8];
        q_entry.sda_in     = s_tdata[9];
        case (s_tuser)
            i2cm_pkg::MODE_TICK:  q_entry.kind = i2cm_pkg::KIND_TICK;
            i2cm_pkg::MODE_START: q_entry.kind = i2cm_pkg::KIND_START;
            i2cm_pkg::MODE_STOP:  q_entry.kind = i2cm_pkg::KIND_STOP;
            i2cm_pkg::MODE_WRITE: q_entry.kind = i2cm_pkg::KIND_WRITE;
            i2cm_pkg::MODE_READ:  q_entry.kind = i2cm_pkg::KIND_READ;
            default:              q_entry.kind = i2cm_pkg::KIND_NONE;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/i2cm_queue.sv
// ============================================================================
// i2cm_queue
// short fifo of classified items between front and back
// ============================================================================
`default_nettype none

module i2cm_queue
#(
    parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire i2cm_pkg::queue_entry_t push_entry,
    output      logic                   full,
    output      logic                   not_empty,
    input  wire logic                   pop,
    output      i2cm_pkg::queue_entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    i2cm_pkg::queue_entry_t store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/i2cm_back.sv
// ============================================================================
// i2cm_back
// pin sequencer: executes one queued item per cycle, unless an untaken result waits, into the output register
// ============================================================================
`default_nettype none

module i2cm_back
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    input  wire logic [15:0]            cfg_data,
    input  wire logic                   q_not_empty,
    input  wire i2cm_pkg::queue_entry_t q_head,
    output      logic                   q_pop,
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [15:0]            m_tdata
);

    localparam logic [3:0] BIT_LIMIT = 4'(i2cm_pkg::BITS_PER_BYTE);

    i2cm_pkg::phase_t phase_reg, phase_next;
    logic [15:0] half_reg;
    logic [15:0] delay_reg, delay_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  read_data_reg, read_data_next;
    logic        ack_to_send_reg, ack_to_send_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        sda_oe_reg, sda_oe_next;
    logic        ack_seen_reg, ack_seen_next;
    logic        done;
    logic [15:0] reload;
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;

    assign reload   = (half_reg == 16'd0) ? 16'd1 : half_reg;
    assign q_pop    = q_not_empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        delay_next       = delay_reg;
        bit_count_next   = bit_count_reg;
        shift_next       = shift_reg;
        read_data_next   = read_data_reg;
        ack_to_send_next = ack_to_send_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        sda_oe_next      = sda_oe_reg;
        ack_seen_next    = ack_seen_reg;
        done             = 1'b0;
        case (q_head.kind)
            i2cm_pkg::KIND_TICK:
            begin
                if (phase_reg != i2cm_pkg::PH_IDLE)
                begin
                    if (delay_reg > 16'd1)
                    begin
                        delay_next = delay_reg - 16'd1;
                    end
                    else
                    begin
                        delay_next = reload;
                        case (phase_reg)
                            i2cm_pkg::PH_ST1:
                            begin
                                sda_next   = 1'b0;
                                phase_next = i2cm_pkg::PH_ST2;
                            end
                            i2cm_pkg::PH_ST2:
                            begin
                                scl_next = 1'b0;
                                done     = 1'b1;
                            end
                            i2cm_pkg::PH_SP1:
                            begin
                                sda_next   = 1'b1;
                                phase_next = i2cm_pkg::PH_SP2;
                            end
                            i2cm_pkg::PH_WB_LOW:
                            begin
                                scl_next   = 1'b1;
                                phase_next = i2cm_pkg::PH_WB_HIGH;
                            end
                            i2cm_pkg::PH_WB_HIGH:
                            begin
                                scl_next       = 1'b0;
                                shift_next     = {shift_reg[6:0], 1'b0};
                                bit_count_next = bit_count_reg + 4'd1;
                                if (bit_count_next < BIT_LIMIT)
                                begin
                                    sda_next   = shift_next[7];
                                    phase_next = i2cm_pkg::PH_WB_LOW;
                                end
                                else
                                begin
                                    sda_oe_next = 1'b0;
                                    phase_next  = i2cm_pkg::PH_WA_LOW;
                                end
                            end
                            i2cm_pkg::PH_WA_LOW:
                            begin
                                scl_next      = 1'b1;
                                ack_seen_next = !q_head.sda_in;
                                phase_next    = i2cm_pkg::PH_WA_HIGH;
                            end
                            i2cm_pkg::PH_WA_HIGH:
                            begin
                                scl_next    = 1'b0;
                                sda_oe_next = 1'b1;
                                done        = 1'b1;
                            end
                            i2cm_pkg::PH_RB_HIGH:
                            begin
                                shift_next     = {shift_reg[7:1], shift_reg[0] | q_head.sda_in};
                                scl_next       = 1'b0;
                                bit_count_next = bit_count_reg + 4'd1;
                                phase_next     = i2cm_pkg::PH_RB_LOW;
                            end
                            i2cm_pkg::PH_RB_LOW:
                            begin
                                if (bit_count_reg < BIT_LIMIT)
                                begin
                                    shift_next = {shift_reg[6:0], 1'b0};
                                    scl_next   = 1'b1;
                                    phase_next = i2cm_pkg::PH_RB_HIGH;
                                end
                                else
                                begin
                                    sda_oe_next    = 1'b1;
                                    sda_next       = !ack_to_send_reg;
                                    read_data_next = shift_reg;
                                    phase_next     = i2cm_pkg::PH_RA_LOW;
                                end
                            end
                            i2cm_pkg::PH_RA_LOW:
                            begin
                                scl_next   = 1'b1;
                                phase_next = i2cm_pkg::PH_RA_HIGH;
                            end
                            i2cm_pkg::PH_RA_HIGH:
                            begin
                                scl_next = 1'b0;
                                done     = 1'b1;
                            end
                            default:
                            begin
                                // stop second half and anything unexpected just end
                                done = 1'b1;
                            end
                        endcase
                        if (done)
                        begin
                            phase_next = i2cm_pkg::PH_IDLE;
                            delay_next = 16'd0;
                        end
                    end
                end
            end
            i2cm_pkg::KIND_START:
            begin
                if (phase_reg == i2cm_pkg::PH_IDLE)
                begin
                    sda_oe_next = 1'b1;
                    sda_next    = 1'b1;
                    scl_next    = 1'b1;
                    phase_next  = i2cm_pkg::PH_ST1;
                    delay_next  = reload;
                end
            end
            i2cm_pkg::KIND_STOP:
            begin
                if (phase_reg == i2cm_pkg::PH_IDLE)
                begin
                    sda_oe_next = 1'b1;
                    sda_next    = 1'b0;
                    scl_next    = 1'b1;
                    phase_next  = i2cm_pkg::PH_SP1;
                    delay_next  = reload;
                end
            end
            i2cm_pkg::KIND_WRITE:
            begin
                if (phase_reg == i2cm_pkg::PH_IDLE)
                begin
                    sda_oe_next    = 1'b1;
                    shift_next     = q_head.write_byte;
                    bit_count_next = 4'd0;
                    sda_next       = q_head.write_byte[7];
                    phase_next     = i2cm_pkg::PH_WB_LOW;
                    delay_next     = reload;
                end
            end
            i2cm_pkg::KIND_READ:
            begin
                if (phase_reg == i2cm_pkg::PH_IDLE)
                begin
                    sda_oe_next      = 1'b0;
                    shift_next       = 8'd0;
                    bit_count_next   = 4'd0;
                    ack_to_send_next = q_head.send_ack;
                    scl_next         = 1'b1;
                    phase_next       = i2cm_pkg::PH_RB_HIGH;
                    delay_next       = reload;
                end
            end
            default:
            begin
                // unknown mode leaves the state alone
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg        <= i2cm_pkg::HALF_PERIOD_RST;
            phase_reg       <= i2cm_pkg::PH_IDLE;
            delay_reg       <= 16'd0;
            bit_count_reg   <= 4'd0;
            shift_reg       <= 8'd0;
            read_data_reg   <= 8'd0;
            ack_to_send_reg <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            sda_oe_reg      <= 1'b0;
            ack_seen_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                half_reg <= cfg_data;
            end
            if (q_pop)
            begin
                phase_reg       <= phase_next;
                delay_reg       <= delay_next;
                bit_count_reg   <= bit_count_next;
                shift_reg       <= shift_next;
                read_data_reg   <= read_data_next;
                ack_to_send_reg <= ack_to_send_next;
                scl_reg         <= scl_next;
                sda_reg         <= sda_next;
                sda_oe_reg      <= sda_oe_next;
                ack_seen_reg    <= ack_seen_next;
                m_tvalid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            m_tdata_reg <= {2'b00, read_data_next, ack_seen_next, done,
                            (phase_next != i2cm_pkg::PH_IDLE), sda_oe_next,
                            sda_next, scl_next};
        end
    end

endmodule

`default_nettype wire

FILE: dv/i2cm_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// i2cm_checker
// predicts the pin result of every item taken by the i2c byte engine and
// compares it field by field with what comes out of the result stream
// ============================================================================

module i2cm_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [2:0]  s_tuser,      // mode
    input  wire logic [15:0] s_tdata,      // write_byte, send_ack, sda_in, zero fill
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,      // scl, sda, sda drive, busy, done, ack, read byte
    output int               errors,
    output int               outstanding
);

    import i2cm_pkg::*;

    // result fields, lowest bit last in the list
    typedef struct packed {
        logic [7:0] read_byte;
        logic       ack_received;
        logic       done;
        logic       busy;
        logic       sda_drive;
        logic       sda_level;
        logic       scl_level;
    } pin_result_t;

    // own copy of the sequencer state
    logic [15:0] half_period;
    phase_t      seq_phase;
    logic [3:0]  bits_done;
    logic [7:0]  shifter;
    logic [15:0] delay_left;
    logic        ack_to_drive;
    logic        scl_q;
    logic        sda_q;
    logic        sda_oe_q;
    logic        ack_seen_q;
    logic [7:0]  last_read;

    pin_result_t expected_pins[$];
    int          err_cnt;

    function automatic void arm_delay(phase_t next_phase);
        seq_phase  = next_phase;
        delay_left = (half_period == 16'd0) ? 16'd1 : half_period;
    endfunction

    // pin changes at the end of a delay, returns 1 when the command is over
    function automatic logic end_of_delay(logic sda_bit);
        case (seq_phase)
            PH_ST1:
            begin
                sda_q = 1'b0;
                arm_delay(PH_ST2);
                return 1'b0;
            end
            PH_ST2:
            begin
                scl_q = 1'b0;
                return 1'b1;
            end
            PH_SP1:
            begin
                sda_q = 1'b1;
                arm_delay(PH_SP2);
                return 1'b0;
            end
            PH_SP2:
                return 1'b1;
            PH_WB_LOW:
            begin
                scl_q = 1'b1;
                arm_delay(PH_WB_HIGH);
                return 1'b0;
            end
            PH_WB_HIGH:
            begin
                scl_q     = 1'b0;
                shifter   = shifter << 1;
                bits_done = bits_done + 4'd1;
                if (bits_done < BITS_PER_BYTE)
                begin
                    sda_q = shifter[7];
                    arm_delay(PH_WB_LOW);
                end
                else
                begin
                    sda_oe_q = 1'b0;
                    arm_delay(PH_WA_LOW);
                end
                return 1'b0;
            end
            PH_WA_LOW:
            begin
                scl_q      = 1'b1;
                ack_seen_q = !sda_bit;
                arm_delay(PH_WA_HIGH);
                return 1'b0;
            end
            PH_WA_HIGH:
            begin
                scl_q    = 1'b0;
                sda_oe_q = 1'b1;
                return 1'b1;
            end
            PH_RB_HIGH:
            begin
                if (sda_bit)
                    shifter[0] = 1'b1;
                scl_q     = 1'b0;
                bits_done = bits_done + 4'd1;
                arm_delay(PH_RB_LOW);
                return 1'b0;
            end
            PH_RB_LOW:
            begin
                if (bits_done < BITS_PER_BYTE)
                begin
                    shifter = shifter << 1;
                    scl_q   = 1'b1;
                    arm_delay(PH_RB_HIGH);
                end
                else
                begin
                    sda_oe_q  = 1'b1;
                    sda_q     = !ack_to_drive;
                    last_read = shifter;
                    arm_delay(PH_RA_LOW);
                end
                return 1'b0;
            end
            PH_RA_LOW:
            begin
                scl_q = 1'b1;
                arm_delay(PH_RA_HIGH);
                return 1'b0;
            end
            PH_RA_HIGH:
            begin
                scl_q = 1'b0;
                return 1'b1;
            end
            default:
                return 1'b1;
        endcase
    endfunction

    // advance the sequencer by one item and report the pins it leaves behind
    function automatic pin_result_t step_engine(logic [2:0] mode, logic [7:0] wbyte,
                                                logic sack, logic sda_bit);
        pin_result_t pins;
        logic        finished;
        finished = 1'b0;
        if (mode == MODE_TICK)
        begin
            if (seq_phase != PH_IDLE)
            begin
                if (delay_left > 16'd1)
                    delay_left = delay_left - 16'd1;
                else if (end_of_delay(sda_bit))
                begin
                    seq_phase  = PH_IDLE;
                    delay_left = 16'd0;
                    finished   = 1'b1;
                end
            end
        end
        else if (seq_phase == PH_IDLE)
        begin
            case (mode)
                MODE_START:
                begin
                    sda_oe_q = 1'b1;
                    sda_q    = 1'b1;
                    scl_q    = 1'b1;
                    arm_delay(PH_ST1);
                end
                MODE_STOP:
                begin
                    sda_oe_q = 1'b1;
                    sda_q    = 1'b0;
                    scl_q    = 1'b1;
                    arm_delay(PH_SP1);
                end
                MODE_WRITE:
                begin
                    sda_oe_q  = 1'b1;
                    shifter   = wbyte;
                    bits_done = 4'd0;
                    sda_q     = wbyte[7];
                    arm_delay(PH_WB_LOW);
                end
                MODE_READ:
                begin
                    sda_oe_q     = 1'b0;
                    shifter      = 8'd0;
                    bits_done    = 4'd0;
                    ack_to_drive = sack;
                    scl_q        = 1'b1;
                    arm_delay(PH_RB_HIGH);
                end
                default:
                    ;
            endcase
        end
        pins.scl_level    = scl_q;
        pins.sda_level    = sda_q;
        pins.sda_drive    = sda_oe_q;
        pins.busy         = (seq_phase != PH_IDLE);
        pins.done         = finished;
        pins.ack_received = ack_seen_q;
        pins.read_byte    = last_read;
        return pins;
    endfunction

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        pin_result_t want;
        pin_result_t got;
        if (!rst_n)
        begin
            half_period  = HALF_PERIOD_RST;
            seq_phase    = PH_IDLE;
            bits_done    = 4'd0;
            shifter      = 8'd0;
            delay_left   = 16'd0;
            ack_to_drive = 1'b0;
            scl_q        = 1'b1;
            sda_q        = 1'b1;
            sda_oe_q     = 1'b0;
            ack_seen_q   = 1'b0;
            last_read    = 8'd0;
            expected_pins.delete();
            err_cnt      = 0;
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                half_period = cfg_data;
            if (s_tvalid && s_tready)
                expected_pins.push_back(step_engine(s_tuser, s_tdata[7:0], s_tdata[8],
                                                    s_tdata[9]));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[13:0];
                if (expected_pins.size() == 0)
                begin
                    $display("%0t: result mismatch, expected none, actual %0h", $time, m_tdata);
                    err_cnt++;
                end
                else
                begin
                    want = expected_pins.pop_front();
                    check_field("scl_level", want.scl_level, got.scl_level);
                    check_field("sda_level", want.sda_level, got.sda_level);
                    check_field("sda_drive", want.sda_drive, got.sda_drive);
                    check_field("busy", want.busy, got.busy);
                    check_field("done", want.done, got.done);
                    check_field("ack_received", want.ack_received, got.ack_received);
                    check_field("read_byte", want.read_byte, got.read_byte);
                end
            end
            errors      <= err_cnt;
            outstanding <= expected_pins.size();
        end
    end

endmodule

FILE: dv/tb_i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_i2c_master_byte_engine
// drives start, stop, write and read commands with the ticks that carry them
// through, under several half periods, with random idling on both streams;
// a checker beside the engine predicts and compares every result
// ============================================================================

module tb_i2c_master_byte_engine;

    import i2cm_pkg::*;

    localparam int          CLK_HIGH_NS   = 6;
    localparam int          CLK_LOW_NS    = 6;
    localparam int          RESET_CYCLES  = 8;
    localparam int          HOLD_CYCLES   = 80;     // long receiver hold-off
    localparam int          SETTLE_CYCLES = 6;      // margin after every result is back
    localparam int          FRAME_DELAYS  = 2;      // delays of a start or a stop
    localparam int          BYTE_DELAYS   = 2 * BITS_PER_BYTE + 2;
    localparam logic [2:0]  MODE_UNUSED   = 3'd5;   // first of the modes with no meaning
    localparam longint      RUN_LIMIT_NS  = 64'd24_000_000;

    // how ticks pick the sampled sda level
    localparam int SDA_ZERO   = 0;
    localparam int SDA_ONE    = 1;
    localparam int SDA_RANDOM = 2;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;       // mode
    logic [15:0] s_tdata;       // write_byte, send_ack, sda_in, zero fill
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;       // scl, sda, sda drive, busy, done, ack, read byte, zero fill

    int fail_count;
    int results_owed;

    // stimulus side bookkeeping
    int cur_hp;                 // half period now in the register
    int ticks_left;             // ticks the running command still needs
    int useful_items;           // items that moved the engine
    bit calm;                   // no idling on either side
    bit steady;                 // sender offers back to back
    bit hold_req;               // ask the receiver for one long hold-off
    int tx_gap_pct;
    int rx_gap_pct;
    int stall_left;

    i2c_master_byte_engine dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    i2cm_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (fail_count),
        .outstanding (results_owed)
    );

    always
    begin
        clk = 1'b0;
        #(CLK_LOW_NS);
        clk = 1'b1;
        #(CLK_HIGH_NS);
    end

    // hard stop in case the engine hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                m_tready  <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < rx_gap_pct)
            begin
                stall_left = $urandom_range(0, 15);
                m_tready  <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic logic sda_for(int pick);
        if (pick == SDA_RANDOM)
            return 1'($urandom_range(0, 1));
        return (pick == SDA_ONE);
    endfunction

    // one item on the input stream; returns just after its transfer
    task automatic send_item(logic [2:0] mode, logic [7:0] wbyte, logic sack, logic sda);
        if (!calm && !steady && $urandom_range(0, 99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'd0, sda, sack, wbyte};
        do
            @(posedge clk);
        while (!s_tready);
        // follow the engine's busy time so commands land where intended
        if (mode == MODE_TICK)
        begin
            if (ticks_left > 0)
            begin
                ticks_left--;
                useful_items++;
            end
        end
        else if (ticks_left == 0 && mode >= MODE_START && mode <= MODE_READ)
        begin
            ticks_left = ((mode == MODE_WRITE || mode == MODE_READ) ? BYTE_DELAYS : FRAME_DELAYS)
                         * ((cur_hp == 0) ? 1 : cur_hp);
            useful_items++;
        end
    endtask

    // a command and the ticks that finish it, with ignored commands mixed in
    task automatic issue(logic [2:0] mode, logic [7:0] wbyte, logic sack,
                         int noise_pct, int sda_pick);
        send_item(mode, wbyte, sack, 1'($urandom_range(0, 1)));
        while (ticks_left > 0)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            else
                send_item(MODE_TICK, 8'($urandom), 1'($urandom_range(0, 1)), sda_for(sda_pick));
        end
    endtask

    // stop offering and wait until every result is back
    task automatic settle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_half_period(logic [15:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_hp = value;
    endtask

    // mostly complete transactions, some lone commands and idle noise
    task automatic random_phase(logic [15:0] hp, int item_goal, bit with_hold);
        int goal;
        int pick;
        set_half_period(hp);
        tx_gap_pct = 15 * $urandom_range(0, 2);
        rx_gap_pct = 15 * $urandom_range(0, 2);
        goal = useful_items + item_goal;
        if (with_hold)
        begin
            // receiver holds off while the sender keeps pushing, so the queue fills
            steady   = 1'b1;
            hold_req = 1'b1;
            issue(MODE_START, 8'($urandom), 1'b0, 0, SDA_RANDOM);
            issue(MODE_WRITE, 8'($urandom), 1'b0, 0, SDA_RANDOM);
            steady   = 1'b0;
        end
        while (useful_items < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                // idle tick or unknown mode, no effect on the engine
                send_item(($urandom_range(0, 1) != 0) ? MODE_TICK
                                                      : MODE_UNUSED + 3'($urandom_range(0, 2)),
                          8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (pick < 14)
                // broken sequence: a lone command
                issue(3'($urandom_range(MODE_START, MODE_READ)), 8'($urandom),
                      1'($urandom_range(0, 1)), 6, SDA_RANDOM);
            else if (pick < 17)
                settle();
            else
            begin
                if (pick < 35)
                begin
                    tx_gap_pct = 15 * $urandom_range(0, 2);
                    rx_gap_pct = 15 * $urandom_range(0, 2);
                end
                issue(MODE_START, 8'($urandom), 1'($urandom_range(0, 1)), 6, SDA_RANDOM);
                repeat ($urandom_range(1, 3))
                    issue(($urandom_range(0, 1) != 0) ? MODE_WRITE : MODE_READ, 8'($urandom),
                          1'($urandom_range(0, 1)), 6, SDA_RANDOM);
                issue(MODE_STOP, 8'($urandom), 1'($urandom_range(0, 1)), 6, SDA_RANDOM);
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 16'd0;
        s_tvalid     = 1'b0;
        s_tuser      = MODE_TICK;
        s_tdata      = 16'd0;
        calm         = 1'b0;
        steady       = 1'b0;
        hold_req     = 1'b0;
        tx_gap_pct   = 0;
        rx_gap_pct   = 0;
        ticks_left   = 0;
        useful_items = 0;
        cur_hp       = HALF_PERIOD_RST;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset pins and idle items, then a stop as the first command after reset
        send_item(MODE_UNUSED, 8'h00, 1'b0, 1'b0);
        send_item(MODE_TICK, 8'hFF, 1'b1, 1'b1);

        // shortest delay: byte and ack extremes
        set_half_period(16'd1);
        issue(MODE_STOP, 8'h5A, 1'b0, 2, SDA_RANDOM);
        issue(MODE_START, 8'h00, 1'b0, 0, SDA_RANDOM);
        issue(MODE_WRITE, 8'hFF, 1'b0, 0, SDA_ZERO);    // acked
        issue(MODE_WRITE, 8'h00, 1'b1, 0, SDA_ONE);     // not acked
        issue(MODE_READ, 8'h00, 1'b1, 0, SDA_ONE);      // all ones, ack driven low
        issue(MODE_READ, 8'hFF, 1'b0, 0, SDA_ZERO);     // all zeros, sda left high
        issue(MODE_WRITE, 8'hA5, 1'b0, 40, SDA_RANDOM); // commands while busy
        issue(MODE_STOP, 8'h00, 1'b0, 0, SDA_RANDOM);
        send_item(MODE_UNUSED + 3'd2, 8'h3C, 1'b1, 1'b0);

        // zero half period behaves as one tick per delay
        set_half_period(16'd0);
        issue(MODE_START, 8'h00, 1'b0, 0, SDA_RANDOM);
        issue(MODE_READ, 8'h00, 1'b1, 0, SDA_RANDOM);
        issue(MODE_STOP, 8'h00, 1'b0, 0, SDA_RANDOM);

        // random transactions
        random_phase(16'd1, 140, 1'b1);
        random_phase(16'd2, 100, 1'b0);
        random_phase(16'd0, 60, 1'b0);
        calm = 1'b1;
        random_phase(16'd3, 100, 1'b0);

        settle();
        if (fail_count == 0 && results_owed == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
